FILE: sv/jebp_pkg.sv
// Shared types and constants for the JPEG entropy bit packer.
`default_nettype none

package jebp_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int NUM_TABLES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Code memory geometry: a 2-bit select reaches at most four tables
    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_TABLES    = 4;
    localparam int ENTRY_W       = 16;

    // Bit string of one symbol: up to 16 code bits plus 12 amplitude bits
    localparam int JOB_BITS  = 28;
    localparam int NBITS_W   = 5;
    localparam int BYTE_BITS = 8;

    // Back-end accumulator: up to 7 pending bits plus one full job
    localparam int ACC_BITS  = JOB_BITS + BYTE_BITS - 1;
    localparam int ACC_CNT_W = 6;

    // Long AC codes get four leading ones ORed in at the top of the code
    localparam logic [15:0] LONG_CODE_ONES = 16'h0f00;
    localparam logic [3:0]  LONG_FIELD_MIN = 4'd11;

    // A byte of all ones is followed by a stuffed zero byte
    localparam logic [7:0] STUFF_TRIGGER = 8'hff;
    localparam logic [7:0] STUFF_BYTE    = 8'h00;

    typedef enum logic [1:0] {
        OP_DC    = 2'd0,
        OP_AC    = 2'd1,
        OP_RAW   = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    // One queued job: left-aligned bit string, or a raw byte in the top bits
    typedef struct packed {
        logic                raw;
        logic [JOB_BITS-1:0] bits;
        logic [NBITS_W-1:0]  nbits;
    } t_job;

endpackage

`default_nettype wire

FILE: sv/jebp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jebp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/jebp_front.sv
// Front end: accepts items, finds the size category, looks up the code and builds the bit string.
`default_nettype none

module jebp_front
    import jebp_pkg::*;
#(
    parameter int NUM_TABLES = NUM_TABLES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [1:0]  i_table_select,
    input  wire logic        [3:0]  i_zero_run,
    input  wire logic signed [11:0] i_coef,
    input  wire logic        [7:0]  i_raw_byte,
    input  wire logic        [7:0]  i_entry_index,
    input  wire logic        [15:0] i_entry_word,
    output logic                    o_push,
    output t_job                    o_job,
    input  wire logic               i_q_ready
);

    localparam int USED_TABLES = (NUM_TABLES < MAX_TABLES) ? NUM_TABLES : MAX_TABLES;
    localparam int MEM_DEPTH   = USED_TABLES * TABLE_ENTRIES;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Number of bits in a 13-bit magnitude (0..12)
    function automatic logic [3:0] bit_len(input logic [12:0] mag);
        logic [3:0] len;
        len = 4'd0;
        for (int i = 0; i < 13; i++) begin
            if (mag[i]) begin
                len = 4'(i + 1);
            end
        end
        return len;
    endfunction

    t_op               op;
    logic              accept;
    logic              sel_ok;
    logic              is_sym;
    logic              coef_neg;
    logic [11:0]       coef_u;
    logic [12:0]       mag;
    logic [3:0]        size;
    logic [11:0]       amp;
    logic [11:0]       amp_l;
    logic [9:0]        raddr_full;
    logic [9:0]        waddr_full;
    logic              ram_we;
    logic              ram_re;
    logic              s2_load;
    logic [ENTRY_W-1:0] rdata;

    // Second-stage registers, aligned with the RAM read data
    logic        r_s2_valid;
    logic        r_s2_raw;
    logic        r_s2_ac;
    logic [3:0]  r_s2_size;
    logic [11:0] r_s2_amp;
    logic [7:0]  r_s2_rawb;

    // Classification at accept
    always_comb begin
        op       = t_op'(i_op);
        accept   = i_valid && o_ready;
        sel_ok   = int'(i_table_select) < NUM_TABLES;
        is_sym   = (op == OP_DC) || (op == OP_AC);
        coef_u   = i_coef;
        coef_neg = coef_u[11];
        mag      = coef_neg ? (13'd0 - {coef_u[11], coef_u}) : {1'b0, coef_u};
        size     = bit_len(mag);
        amp      = coef_neg ? (coef_u - 12'd1) : coef_u;
        // left-align; bits above the size category fall off the top
        amp_l    = amp << (4'd12 - size);
        raddr_full = (op == OP_DC) ? {i_table_select, 4'd0, size}
                                   : {i_table_select, size, i_zero_run};
        waddr_full = {i_table_select, i_entry_index};
        ram_we   = accept && (op == OP_WRITE) && sel_ok;
        ram_re   = accept && is_sym && sel_ok;
        s2_load  = accept && ((op == OP_RAW) || (is_sym && sel_ok));
    end

    jebp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_code_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_full[ADDR_W-1:0]),
        .i_wdata (i_entry_word),
        .i_re    (ram_re),
        .i_raddr (raddr_full[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= 1'b1;
        end else if (o_push) begin
            r_s2_valid <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_raw  <= (op == OP_RAW);
            r_s2_ac   <= (op == OP_AC);
            r_s2_size <= size;
            r_s2_amp  <= amp_l;
            r_s2_rawb <= i_raw_byte;
        end
    end

    assign o_push  = r_s2_valid && i_q_ready;
    assign o_ready = !r_s2_valid || i_q_ready;

    // Code decode and bit string assembly
    logic [3:0]  field;
    logic [4:0]  clen;
    logic [15:0] code;
    logic [15:0] code_l;

    always_comb begin
        field = rdata[3:0];
        code  = {4'd0, rdata[15:4]};
        if (r_s2_ac) begin
            clen = {1'b0, field} + 5'd1;
            if (field > LONG_FIELD_MIN) begin
                code = code | (LONG_CODE_ONES << (field - LONG_FIELD_MIN));
            end
        end else begin
            clen = {1'b0, field};
        end
        code_l = code << (5'd16 - clen);

        o_job.raw = r_s2_raw;
        if (r_s2_raw) begin
            o_job.bits  = {r_s2_rawb, {(JOB_BITS - BYTE_BITS){1'b0}}};
            o_job.nbits = '0;
        end else begin
            o_job.bits  = {code_l, 12'd0} | ({r_s2_amp, 16'd0} >> clen);
            o_job.nbits = clen + {1'b0, r_s2_size};
        end
    end

`ifndef SYNTHESIS
    // A code lookup always lands in the second stage the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_s2_valid && !r_s2_raw))
        else $error("code lookup not captured in stage two");
`endif

endmodule

`default_nettype wire

FILE: sv/jebp_queue.sv
// Short job queue between the front end and the byte packer.
`default_nettype none

module jebp_queue
    import jebp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_nonempty
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_BW = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_BW-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_BW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_BW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job      = r_mem[r_rd];
    assign o_ready    = r_count != CNT_BW'(DEPTH);
    assign o_nonempty = r_count != '0;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNT_BW'(DEPTH))))
        else $error("push into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_count == '0)))
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: sv/jebp_back.sv
// Back end: packs job bits into bytes, stuffs zeros after 0xFF, aligns for raw bytes.
`default_nettype none

module jebp_back
    import jebp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_nonempty,
    input  wire t_job       i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic      [7:0] o_out_byte,
    output logic            o_last
);

    // Bit accumulator, MSB first, zero beyond the count
    logic [ACC_BITS-1:0]  r_acc,  n_acc;
    logic [ACC_CNT_W-1:0] r_cnt,  n_cnt;
    logic                 r_stuff, n_stuff;
    logic                 r_stuff_last, n_stuff_last;
    logic                 r_pad,  n_pad;
    logic                 r_rawp, n_rawp;
    logic [7:0]           r_rawb, n_rawb;

    // Output register
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic                 out_free;
    logic                 need;
    logic                 do_emit;
    logic [7:0]           emit_byte;
    logic                 emit_last;
    logic                 rem_small;
    logic [ACC_BITS-1:0]  post_acc;
    logic [ACC_CNT_W-1:0] post_cnt;
    logic                 post_stuff;
    logic                 post_stuff_last;
    logic                 post_pad;
    logic                 post_rawp;
    logic                 post_idle;

    // One emit step, then take the next job once nothing is left to send
    always_comb begin
        out_free = !r_ovalid || i_ready;
        need     = r_stuff || r_pad || r_rawp || (r_cnt >= ACC_CNT_W'(BYTE_BITS));
        do_emit  = need && out_free;

        post_acc        = r_acc;
        post_cnt        = r_cnt;
        post_stuff      = r_stuff;
        post_stuff_last = r_stuff_last;
        post_pad        = r_pad;
        post_rawp       = r_rawp;
        emit_byte       = STUFF_BYTE;
        emit_last       = 1'b0;
        rem_small       = 1'b0;

        if (do_emit) begin
            if (r_stuff) begin
                emit_byte  = STUFF_BYTE;
                emit_last  = r_stuff_last;
                post_stuff = 1'b0;
            end else if (r_pad) begin
                // partial byte, zero padded, unstuffed
                emit_byte = r_acc[ACC_BITS-1 -: BYTE_BITS];
                post_acc  = '0;
                post_cnt  = '0;
                post_pad  = 1'b0;
            end else if (r_rawp) begin
                emit_byte = r_rawb;
                emit_last = 1'b1;
                post_rawp = 1'b0;
            end else begin
                emit_byte = r_acc[ACC_BITS-1 -: BYTE_BITS];
                post_acc  = r_acc << BYTE_BITS;
                post_cnt  = r_cnt - ACC_CNT_W'(BYTE_BITS);
                rem_small = post_cnt < ACC_CNT_W'(BYTE_BITS);
                if (emit_byte == STUFF_TRIGGER) begin
                    post_stuff      = 1'b1;
                    post_stuff_last = rem_small;
                end else begin
                    emit_last = rem_small;
                end
            end
        end

        post_idle = !(post_stuff || post_pad || post_rawp ||
                      (post_cnt >= ACC_CNT_W'(BYTE_BITS)));
        o_pop     = post_idle && i_nonempty;

        n_acc        = post_acc;
        n_cnt        = post_cnt;
        n_stuff      = post_stuff;
        n_stuff_last = post_stuff_last;
        n_pad        = post_pad;
        n_rawp       = post_rawp;
        n_rawb       = r_rawb;

        if (o_pop) begin
            if (i_job.raw) begin
                n_pad  = post_cnt != '0;
                n_rawp = 1'b1;
                n_rawb = i_job.bits[JOB_BITS-1 -: BYTE_BITS];
            end else begin
                n_acc = post_acc | ({i_job.bits, {(BYTE_BITS - 1){1'b0}}} >> post_cnt[2:0]);
                n_cnt = post_cnt + ACC_CNT_W'(i_job.nbits);
            end
        end
    end

    // Packer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_cnt        <= '0;
            r_stuff      <= 1'b0;
            r_stuff_last <= 1'b0;
            r_pad        <= 1'b0;
            r_rawp       <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_cnt        <= n_cnt;
            r_stuff      <= n_stuff;
            r_stuff_last <= n_stuff_last;
            r_pad        <= n_pad;
            r_rawp       <= n_rawp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rawb <= n_rawb;
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (do_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_obyte <= emit_byte;
            r_olast <= emit_last;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;

`ifndef SYNTHESIS
    // A pending stuffed zero always sits behind a 0xFF still in the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuff |-> (r_ovalid && (r_obyte == STUFF_TRIGGER)))
        else $error("stuff pending without 0xFF in output register");

    // Raw alignment starts only from a partial byte with no stuffing owed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad || r_rawp) |-> ((r_cnt < ACC_CNT_W'(BYTE_BITS)) && !r_stuff))
        else $error("raw byte pending with full bytes or stuffing owed");
`endif

endmodule

`default_nettype wire

FILE: sv/jpeg_entropy_bit_packer.sv
// Top level of the JPEG entropy bit packer: front end, job queue and byte packer.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one operation per transfer:
//   DC or AC symbol, raw byte, or code table write. Output channel
//   (o_valid / i_ready) carries one stream byte per transfer; o_last marks
//   the final byte caused by one input.
//   Code tables must be written before any symbol uses them; the code
//   memory is not cleared at reset. Reset empties the queue and clears the
//   partial byte and bit count; no clearing pass, first transfer the cycle
//   after reset.
//   A symbol goes through the code lookup at the transfer edge, then the
//   queue, the packer load and the output register, where its first byte appears.
//   The packer sends one byte per cycle while the receiver keeps taking
//   them, and takes the next job once less than a full byte is left.
//   Table writes and ignored symbols take no packer time.
//   When the receiver stalls, the byte stays in the output register, the
//   queue fills, and o_ready drops once the queue and lookup stage are full.
`default_nettype none

module jpeg_entropy_bit_packer
    import jebp_pkg::*;
#(
    parameter int NUM_TABLES  = NUM_TABLES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [1:0]  i_table_select,
    input  wire logic        [3:0]  i_zero_run,
    input  wire logic signed [11:0] i_coef,
    input  wire logic        [7:0]  i_raw_byte,
    input  wire logic        [7:0]  i_entry_index,
    input  wire logic        [15:0] i_entry_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic             [7:0]  o_out_byte,
    output logic                    o_last
);

    logic push;
    t_job push_job;
    logic q_ready;
    logic pop;
    t_job head_job;
    logic q_nonempty;

    jebp_front #(
        .NUM_TABLES (NUM_TABLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_table_select (i_table_select),
        .i_zero_run     (i_zero_run),
        .i_coef         (i_coef),
        .i_raw_byte     (i_raw_byte),
        .i_entry_index  (i_entry_index),
        .i_entry_word   (i_entry_word),
        .o_push         (push),
        .o_job          (push_job),
        .i_q_ready      (q_ready)
    );

    jebp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_ready    (q_ready),
        .i_pop      (pop),
        .o_job      (head_job),
        .o_nonempty (q_nonempty)
    );

    jebp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire
